/* rtl/md5cr_pkg.sv */
// ----------------------------------------------------------------------------
// md5cr_pkg
// Shared types, constants and helper functions for the salted MD5
// challenge responder.
// ----------------------------------------------------------------------------
`default_nettype none

package md5cr_pkg;

  localparam int unsigned HeaderBytesDef = 3;
  localparam int unsigned BodyBytes      = 16;
  localparam int unsigned CfgRegs        = 4;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [CfgIdxW-1:0] REG_SALT0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SALT1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SALT2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SALT3 = 2'd3;

  localparam logic [31:0] SALT0_RST = 32'hD925_5F0F;
  localparam logic [31:0] SALT1_RST = 32'h2335_4E19;
  localparam logic [31:0] SALT2_RST = 32'hBA73_9CCD;
  localparam logic [31:0] SALT3_RST = 32'hC4A9_1765;

  localparam logic [31:0] MD5_INIT [4] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
  };

  // Padding words of the single block: the 0x80 marker and the bit length.
  localparam logic [31:0] PAD_MARK_WORD = 32'h0000_0080;
  localparam logic [31:0] PAD_LEN_WORD  = 32'h0000_0100;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef logic [15:0][31:0] md5cr_block_t;
  typedef logic [3:0][31:0]  md5cr_digest_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

`default_nettype wire

/* rtl/md5_challenge_responder_top.sv */
// ----------------------------------------------------------------------------
// md5_challenge_responder_top
// Receives a challenge packet byte by byte, hashes challenge || salt with MD5
// and sends back the header, the digest and an XOR check byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                              Handshake
//  rx       in         rx_byte_i                            rx_valid_i / rx_ready_o
//  tx       out        tx_byte_o, tx_last_o                 tx_valid_o / tx_ready_i
//  cfg      in         cfg_index_i, cfg_data_i              cfg_we_i, no wait
//
//  Header and challenge bytes are taken one per cycle.
//  The check byte starts the hash: 64 rounds, each a sum step and a rotate step,
//  then a final add step and a digest handover, all with rx not ready.
//  HEADER_BYTES + 17 response items leave at one item per cycle while tx_ready_i is high.
//  The tx output register holds its item while tx_ready_i is low.
//  Reset is asynchronous; the salt words return to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_challenge_responder_top
  import md5cr_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               rx_valid_i,
  output      logic               rx_ready_o,
  output      logic [7:0]         tx_byte_o,
  output      logic               tx_last_o,
  output      logic               tx_valid_o,
  input  wire logic               tx_ready_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int unsigned PacketBytes = HEADER_BYTES + BodyBytes + 1;
  localparam int unsigned OutBytes    = HEADER_BYTES + BodyBytes + 1;
  localparam int unsigned PosW        = $clog2(PacketBytes);
  localparam int unsigned OutW        = $clog2(OutBytes + 1);
  localparam int unsigned HdrAw       = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  localparam logic [1:0] ST_RX   = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_TX   = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [PosW-1:0] pos_q;
  logic [OutW-1:0] out_idx_q;
  logic [7:0]      xor_q;
  logic            tx_valid_q;
  logic            tx_last_q;
  logic [7:0]      tx_byte_q;
  logic [31:0]     salt_q [CfgRegs];
  logic [7:0]      header_q [HEADER_BYTES];
  logic [7:0]      body_q [BodyBytes];

  logic            rx_fire;
  logic            tx_fire;
  logic            last_rx;
  logic            core_start;
  logic            core_done;
  md5cr_block_t    msg;
  md5cr_digest_t   digest;
  logic            load_slot;
  logic            out_all;
  logic [OutW-1:0] dig_idx;
  logic [31:0]     dig_word;
  logic [7:0]      dig_byte;
  logic [7:0]      next_byte;
  logic [HdrAw-1:0] hdr_rd_idx;

  assign rx_ready_o = (state_q == ST_RX);
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign tx_fire    = tx_valid_q && tx_ready_i;
  assign last_rx    = (pos_q == PosW'(PacketBytes - 1));
  assign core_start = rx_fire && last_rx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q[0] <= SALT0_RST;
      salt_q[1] <= SALT1_RST;
      salt_q[2] <= SALT2_RST;
      salt_q[3] <= SALT3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SALT0: salt_q[0] <= cfg_data_i;
        REG_SALT1: salt_q[1] <= cfg_data_i;
        REG_SALT2: salt_q[2] <= cfg_data_i;
        REG_SALT3: salt_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      if (pos_q < PosW'(HEADER_BYTES)) begin
        header_q[pos_q[HdrAw-1:0]] <= rx_byte_i;
      end else if (pos_q < PosW'(HEADER_BYTES + BodyBytes)) begin
        body_q[4'(pos_q - PosW'(HEADER_BYTES))] <= rx_byte_i;
      end
    end
  end

  always_comb begin
    msg = '0;
    for (int j = 0; j < 4; j++) begin
      msg[j]     = {body_q[4*j+3], body_q[4*j+2], body_q[4*j+1], body_q[4*j]};
      msg[j + 4] = bswap32(salt_q[j]);
    end
    msg[8]  = PAD_MARK_WORD;
    msg[14] = PAD_LEN_WORD;
  end

  md5cr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (core_start),
    .msg_i    (msg),
    .done_o   (core_done),
    .digest_o (digest)
  );

  assign out_all    = (out_idx_q == OutW'(OutBytes));
  assign load_slot  = (state_q == ST_TX) && !out_all && (!tx_valid_q || tx_ready_i);
  assign dig_idx    = out_idx_q - OutW'(HEADER_BYTES);
  assign dig_word   = digest[dig_idx[3:2]];
  assign dig_byte   = 8'(dig_word >> {dig_idx[1:0], 3'b000});
  assign hdr_rd_idx = HdrAw'(out_idx_q);

  always_comb begin
    if (out_idx_q < OutW'(HEADER_BYTES)) begin
      next_byte = header_q[hdr_rd_idx];
    end else if (out_idx_q < OutW'(OutBytes - 1)) begin
      next_byte = dig_byte;
    end else begin
      next_byte = xor_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RX:   if (core_start) state_d = ST_HASH;
      ST_HASH: if (core_done) state_d = ST_TX;
      ST_TX:   if (out_all && (!tx_valid_q || tx_fire)) state_d = ST_RX;
      default: state_d = ST_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      pos_q      <= '0;
      out_idx_q  <= '0;
      xor_q      <= '0;
      tx_valid_q <= 1'b0;
      tx_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rx_fire) begin
        pos_q <= last_rx ? '0 : pos_q + PosW'(1);
      end
      if (core_done) begin
        out_idx_q <= '0;
        xor_q     <= '0;
      end else if (load_slot) begin
        out_idx_q  <= out_idx_q + OutW'(1);
        tx_valid_q <= 1'b1;
        tx_last_q  <= (out_idx_q == OutW'(OutBytes - 1));
        if (out_idx_q != OutW'(OutBytes - 1)) begin
          xor_q <= xor_q ^ next_byte;
        end
      end else if (tx_fire) begin
        tx_valid_q <= 1'b0;
        tx_last_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_slot) begin
      tx_byte_q <= next_byte;
    end
  end

  assign tx_valid_o = tx_valid_q;
  assign tx_last_o  = tx_last_q;
  assign tx_byte_o  = tx_byte_q;

  a_rx_not_during_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_ready_o |-> !tx_valid_o)
    else $error("Receiver open while a response item is pending.");

  a_last_returns_to_rx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && tx_ready_i && tx_last_o) |=> rx_ready_o)
    else $error("Block did not return to receive after the last item.");

  a_start_closes_rx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_start |=> !rx_ready_o)
    else $error("Receiver still open after the hash started.");

  a_last_only_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_last_o |-> tx_valid_o)
    else $error("Last flag raised without a valid item.");

endmodule

`default_nettype wire

/* rtl/md5cr_core.sv */
// ----------------------------------------------------------------------------
// md5cr_core
// Iterative MD5 compression of one 512-bit block, starting from the standard
// initial values. Each round is split into a sum step and a rotate step.
// ----------------------------------------------------------------------------
`default_nettype none

module md5cr_core
  import md5cr_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire md5cr_block_t  msg_i,
  output      logic          done_o,
  output      md5cr_digest_t digest_o
);

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_SUM  = 2'd1;
  localparam logic [1:0] CS_ROT  = 2'd2;
  localparam logic [1:0] CS_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic        done_q, done_d;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] tmp_q;
  logic [31:0] f_w;
  logic [3:0]  g_w;
  logic [3:0]  r4_w;

  assign r4_w = round_q[3:0];

  always_comb begin
    case (round_q[5:4])
      2'd0: begin
        f_w = (b_q & c_q) | (~b_q & d_q);
        g_w = r4_w;
      end
      2'd1: begin
        f_w = (d_q & b_q) | (~d_q & c_q);
        g_w = 4'((r4_w << 2) + r4_w + 4'd1);
      end
      2'd2: begin
        f_w = b_q ^ c_q ^ d_q;
        g_w = 4'((r4_w << 1) + r4_w + 4'd5);
      end
      default: begin
        f_w = c_q ^ (b_q | ~d_q);
        g_w = 4'((r4_w << 3) - r4_w);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    done_d  = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          state_d = CS_SUM;
          round_d = '0;
        end
      end
      CS_SUM: begin
        state_d = CS_ROT;
      end
      CS_ROT: begin
        round_d = round_q + 6'd1;
        state_d = (round_q == 6'd63) ? CS_FIN : CS_SUM;
      end
      CS_FIN: begin
        state_d = CS_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      round_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= MD5_INIT[0];
      b_q <= MD5_INIT[1];
      c_q <= MD5_INIT[2];
      d_q <= MD5_INIT[3];
    end else begin
      if (state_q == CS_IDLE && start_i) begin
        a_q <= MD5_INIT[0];
        b_q <= MD5_INIT[1];
        c_q <= MD5_INIT[2];
        d_q <= MD5_INIT[3];
      end else if (state_q == CS_ROT) begin
        a_q <= d_q;
        d_q <= c_q;
        c_q <= b_q;
        b_q <= b_q + rotl32(tmp_q, MD5_ROT[{round_q[5:4], round_q[1:0]}]);
      end else if (state_q == CS_FIN) begin
        a_q <= a_q + MD5_INIT[0];
        b_q <= b_q + MD5_INIT[1];
        c_q <= c_q + MD5_INIT[2];
        d_q <= d_q + MD5_INIT[3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CS_SUM) begin
      tmp_q <= a_q + f_w + MD5_K[round_q] + msg_i[g_w];
    end
  end

  assign done_o   = done_q;
  assign digest_o = {d_q, c_q, b_q, a_q};

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Salted MD5 challenge responder testbench
// Sends challenge packets byte by byte under random bursts and gaps, with a
// randomly stalling receiver and salt changes between packets. An independent
// MD5 predictor computes each response item, which the monitor compares
// with the response stream in order.
// ----------------------------------------------------------------------------

module testbench;
  import md5cr_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int HdrLen       = HeaderBytesDef;
  localparam int PacketLen    = HdrLen + BodyBytes + 1;
  localparam int RandPackets  = 21;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 40;
  localparam int CycleLimit   = 400000;

  typedef enum logic [1:0] {PLAN_BYTE, PLAN_SALT_WRITE, PLAN_FLUSH} plan_kind_e;

  typedef struct packed {
    plan_kind_e          kind;
    logic [CfgIdxW-1:0]  index;
    logic [31:0]         data;
  } plan_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } resp_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [7:0] EdgeChallenge [16] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
    8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h00, 8'h00, 8'hFF, 8'hFF
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic [7:0]         rx_byte_i   = '0;
  logic               rx_valid_i  = 1'b0;
  logic               rx_ready_o;
  logic [7:0]         tx_byte_o;
  logic               tx_last_o;
  logic               tx_valid_o;
  logic               tx_ready_i  = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;

  logic [31:0] salt_word [4] = '{32'hD925_5F0F, 32'h2335_4E19, 32'hBA73_9CCD, 32'hC4A9_1765};
  logic [7:0]  header_copy [HdrLen];
  logic [7:0]  challenge_copy [16];
  int          rx_pos = 0;

  resp_t response_q [$];
  plan_t packet_plan_q [$];

  logic rx_fire      = 1'b0;
  int   quiet_cycles = 0;
  int   n_mismatch   = 0;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  int   gap_left     = 0;
  int   stall_mode   = 0;
  int   stall_left   = 0;

  md5_challenge_responder_top #(
    .HEADER_BYTES(HdrLen)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .tx_byte_o  (tx_byte_o),
    .tx_last_o  (tx_last_o),
    .tx_valid_o (tx_valid_o),
    .tx_ready_i (tx_ready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // MD5 of the single padded block challenge || salt, from the current copies.
  function automatic logic [3:0][31:0] md5_salted_digest();
    logic [7:0]  msg [64];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [4:0]  s;
    int          i, g;
    for (i = 0; i < 64; i++) msg[i] = 8'h00;
    for (i = 0; i < 16; i++) begin
      msg[i]      = challenge_copy[i];
      msg[16 + i] = salt_word[i / 4][31 - 8 * (i % 4) -: 8];
    end
    msg[32] = 8'h80;
    msg[57] = 8'h01;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg[4 * i + 3], msg[4 * i + 2], msg[4 * i + 1], msg[4 * i]};
    end
    a = 32'h6745_2301;
    b = 32'hefcd_ab89;
    c = 32'h98ba_dcfe;
    d = 32'h1032_5476;
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s   = RotAmount[(i / 16) * 4 + i % 4];
      sum = a + f + RoundConst[i] + w[g];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (6'd32 - s)));
      a   = t;
    end
    return {d + 32'h1032_5476, c + 32'h98ba_dcfe, b + 32'hefcd_ab89, a + 32'h6745_2301};
  endfunction

  task automatic queue_byte(input logic [7:0] value);
    packet_plan_q.push_back(plan_t'{kind: PLAN_BYTE, index: '0, data: {24'h0, value}});
  endtask

  task automatic queue_flush();
    packet_plan_q.push_back(plan_t'{kind: PLAN_FLUSH, index: '0, data: '0});
  endtask

  task automatic queue_salt(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
    packet_plan_q.push_back(plan_t'{kind: PLAN_SALT_WRITE, index: REG_SALT0, data: w0});
    packet_plan_q.push_back(plan_t'{kind: PLAN_SALT_WRITE, index: REG_SALT1, data: w1});
    packet_plan_q.push_back(plan_t'{kind: PLAN_SALT_WRITE, index: REG_SALT2, data: w2});
    packet_plan_q.push_back(plan_t'{kind: PLAN_SALT_WRITE, index: REG_SALT3, data: w3});
  endtask

  always @(negedge clk_i) begin
    logic               nxt_valid;
    logic [7:0]         nxt_byte;
    logic               nxt_we;
    logic [CfgIdxW-1:0] nxt_index;
    logic [31:0]        nxt_data;
    logic               nxt_ready;
    if (rst_ni) begin
      nxt_valid = rx_valid_i && !rx_fire;
      nxt_byte  = rx_byte_i;
      nxt_we    = 1'b0;
      nxt_index = cfg_index_i;
      nxt_data  = cfg_data_i;
      if (!nxt_valid && packet_plan_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (packet_plan_q[0].kind)
            PLAN_BYTE: begin
              nxt_valid = 1'b1;
              nxt_byte  = packet_plan_q[0].data[7:0];
              void'(packet_plan_q.pop_front());
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) == 0) gap_left = 0;
                else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(40, 160);
                else gap_left = $urandom_range(1, 10);
              end
            end
            PLAN_SALT_WRITE: begin
              if (response_q.size() == 0 && quiet_cycles >= SettleCycles) begin
                nxt_we    = 1'b1;
                nxt_index = packet_plan_q[0].index;
                nxt_data  = packet_plan_q[0].data;
                void'(packet_plan_q.pop_front());
              end
            end
            PLAN_FLUSH: begin
              if (response_q.size() == 0) void'(packet_plan_q.pop_front());
            end
            default: ;
          endcase
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_mode)
        0:       nxt_ready = 1'b1;
        1:       nxt_ready = 1'($urandom_range(0, 1));
        2:       nxt_ready = (cycle_count % 4 == 0);
        default: nxt_ready = ($urandom_range(0, 7) == 0);
      endcase
      rx_valid_i  <= nxt_valid;
      rx_byte_i   <= nxt_byte;
      cfg_we_i    <= nxt_we;
      cfg_index_i <= nxt_index;
      cfg_data_i  <= nxt_data;
      tx_ready_i  <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    resp_t            want;
    logic [3:0][31:0] digest;
    logic [7:0]       xsum;
    logic [7:0]       db;
    int               k;
    if (!rst_ni) begin
      rx_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rx_fire <= rx_valid_i && rx_ready_o;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SALT0: salt_word[0] = cfg_data_i;
          REG_SALT1: salt_word[1] = cfg_data_i;
          REG_SALT2: salt_word[2] = cfg_data_i;
          REG_SALT3: salt_word[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (rx_valid_i && rx_ready_o) begin
        if (rx_pos < HdrLen) header_copy[rx_pos] = rx_byte_i;
        else if (rx_pos < HdrLen + BodyBytes) challenge_copy[rx_pos - HdrLen] = rx_byte_i;
        if (rx_pos == PacketLen - 1) begin
          rx_pos = 0;
          digest = md5_salted_digest();
          xsum   = 8'h00;
          for (k = 0; k < HdrLen; k++) begin
            xsum ^= header_copy[k];
            response_q.push_back(resp_t'{data: header_copy[k], last: 1'b0});
          end
          for (k = 0; k < 16; k++) begin
            db = digest[k / 4][8 * (k % 4) +: 8];
            xsum ^= db;
            response_q.push_back(resp_t'{data: db, last: 1'b0});
          end
          response_q.push_back(resp_t'{data: xsum, last: 1'b1});
        end else begin
          rx_pos++;
        end
      end
      if (tx_valid_o && tx_ready_i) begin
        if (response_q.size() == 0) begin
          if (n_mismatch < 10) begin
            $display("Unexpected response item: byte %02h last %0b", tx_byte_o, tx_last_o);
          end
          n_mismatch++;
        end else begin
          want = response_q.pop_front();
          if (tx_byte_o !== want.data || tx_last_o !== want.last) begin
            if (n_mismatch < 10) begin
              $display("Response mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.data, want.last, tx_byte_o, tx_last_o);
            end
            n_mismatch++;
          end
        end
      end
      if (response_q.size() == 0 && !tx_valid_o) quiet_cycles <= quiet_cycles + 1;
      else quiet_cycles <= 0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int         p, i, style;
    logic [7:0] value;
    // The first packet runs on the reset salt and covers the byte extremes.
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h80);
    for (i = 0; i < 16; i++) queue_byte(EdgeChallenge[i]);
    queue_byte(8'hFF);
    queue_flush();
    for (p = 0; p < RandPackets; p++) begin
      case (p)
        3:  queue_salt(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        7:  queue_salt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        11: queue_salt($urandom(), $urandom(), $urandom(), $urandom());
        15: queue_salt(32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, $urandom());
        18: queue_salt(32'hD925_5F0F, 32'h2335_4E19, 32'hBA73_9CCD, 32'hC4A9_1765);
        default: ;
      endcase
      if (p % 6 == 5) queue_flush();
      style = $urandom_range(0, 7);
      for (i = 0; i < PacketLen; i++) begin
        case (style)
          0:       value = (i < HdrLen) ? 8'(($urandom_range(0, 255))) : 8'h00;
          1:       value = (i < HdrLen) ? 8'(($urandom_range(0, 255))) : 8'hFF;
          default: value = 8'($urandom_range(0, 255));
        endcase
        queue_byte(value);
      end
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (packet_plan_q.size() > 0 || rx_valid_i || response_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_mismatch == 0 && response_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
